// ----- rtl/core/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the sample timestamp tracker.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned TsW     = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned FreqW   = 24;
  localparam int unsigned SpfW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // Conversion datapath
  localparam int unsigned TpsW     = 20;
  localparam logic [TpsW-1:0] TicksPerSec = 20'd1000000;
  localparam int unsigned NumW     = CountW + TpsW + 1;  // product plus rounding term
  localparam int unsigned MulSteps = TpsW;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned CntW     = 6;

  localparam logic [CfgIdxW-1:0] CfgFreq = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpf  = 2'd1;

  typedef enum logic [CmdW-1:0] {
    CmdLoad   = 3'd0,
    CmdAdd    = 3'd1,
    CmdCommit = 3'd2,
    CmdPeek   = 3'd3,
    CmdFrame  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StRnd,
    StDiv,
    StDone
  } state_e;

endpackage

// ----- rtl/core/stt_in_if.sv -----
// ----------------------------------------------------------------------------
// stt_in_if
// Command channel: valid/ready handshake with command and operands.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic                              valid;
  logic                              ready;
  logic [stt_pkg::CmdW-1:0]          command;
  logic signed [stt_pkg::TsW-1:0]    timestamp_in;
  logic [stt_pkg::CountW-1:0]        sample_count;

  modport source (output valid, command, timestamp_in, sample_count, input ready);
  modport sink   (input valid, command, timestamp_in, sample_count, output ready);
endinterface

// ----- rtl/core/stt_out_if.sv -----
// ----------------------------------------------------------------------------
// stt_out_if
// Result channel: valid/ready handshake carrying a tick count.
// ----------------------------------------------------------------------------
interface stt_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [stt_pkg::TsW-1:0] ticks;

  modport source (output valid, ticks, input ready);
  modport sink   (input valid, ticks, output ready);
endinterface

// ----- rtl/core/sample_timestamp_tracker.sv -----
// Load base and add samples complete in the cycle they transfer and the block
// is ready again in the next cycle. Commit, peek and frame duration run, when
// a sampling frequency is set, as a setup, 20 shift-add steps of the x1000000
// multiply, a rounding add, 53 restoring division steps at one quotient bit
// per cycle and a final add; when the frequency is zero they go straight to
// the final add, which waits until the output register is free. The result
// sits in an output register, so a new command is taken while it waits.
// ----------------------------------------------------------------------------
// sample_timestamp_tracker
// Base timestamp plus sample count, converted to microsecond ticks by a
// bit-serial multiply and divide.
// ----------------------------------------------------------------------------
module sample_timestamp_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stt_pkg::CfgW-1:0]     cfg_data_i,
  stt_in_if.sink                       in_i,
  stt_out_if.source                    out_o
);
  import stt_pkg::*;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [FreqW-1:0]   freq_q, freq_d;
  logic [SpfW-1:0]    spf_q, spf_d;
  logic [TsW-1:0]     base_q, base_d;
  logic [CountW-1:0]  accum_q, accum_d;
  logic [CountW-1:0]  opnd_q, opnd_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [FreqW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [TsW-1:0]     out_ticks_q, out_ticks_d;

  logic [FreqW:0]     trial;
  logic               trial_ge;
  logic [FreqW:0]     trial_diff;
  logic [TsW-1:0]     result;

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.ticks = out_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q      <= '0;
      spf_q       <= SpfW'(1024);
      base_q      <= '0;
      accum_q     <= '0;
      cnt_q       <= '0;
      cmd_q       <= CmdLoad;
      out_valid_q <= 1'b0;
    end else begin
      freq_q      <= freq_d;
      spf_q       <= spf_d;
      base_q      <= base_d;
      accum_q     <= accum_d;
      cnt_q       <= cnt_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q      <= opnd_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    out_ticks_q <= out_ticks_d;
  end

  // One restoring division step: shift the next numerator bit into the remainder
  assign trial      = {rem_q, num_q[NumW-1]};
  assign trial_diff = trial - {1'b0, freq_q};
  assign trial_ge   = (trial >= {1'b0, freq_q});
  assign result     = (cmd_q == CmdFrame) ? {{(TsW-NumW){1'b0}}, num_q}
                                          : base_q + {{(TsW-NumW){1'b0}}, num_q};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    freq_d      = freq_q;
    spf_d       = spf_q;
    base_d      = base_q;
    accum_d     = accum_q;
    opnd_d      = opnd_q;
    num_d       = num_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_ticks_d = out_ticks_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgFreq && cfg_data_i[FreqW-1:0] != '0) begin
        freq_d = cfg_data_i[FreqW-1:0];
      end else if (cfg_idx_i == CfgSpf) begin
        spf_d = cfg_data_i[SpfW-1:0];
      end
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          case (cmd_e'(in_i.command))
            CmdLoad: begin
              base_d  = in_i.timestamp_in;
              accum_d = '0;
            end
            CmdAdd: begin
              accum_d = accum_q + in_i.sample_count;
            end
            CmdCommit, CmdPeek, CmdFrame: begin
              cmd_d  = cmd_e'(in_i.command);
              opnd_d = (cmd_e'(in_i.command) == CmdFrame) ?
                       {{(CountW-SpfW){1'b0}}, spf_q} : accum_q;
              num_d  = '0;
              rem_d  = '0;
              cnt_d  = CntW'(MulSteps - 1);
              // No conversion without a frequency: the zero quotient goes out as is
              state_d = (freq_q == '0) ? StDone : StMul;
            end
            default: begin
            end
          endcase
        end
      end
      StMul: begin
        // MSB-first shift-add over the bits of the tick rate
        num_d = {num_q[NumW-2:0], 1'b0} +
                (TicksPerSec[cnt_q[4:0]] ? {{(NumW-CountW){1'b0}}, opnd_q} : '0);
        if (cnt_q == '0) begin
          state_d = StRnd;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StRnd: begin
        num_d   = num_q + {{(NumW-FreqW+1){1'b0}}, freq_q[FreqW-1:1]};
        cnt_d   = CntW'(DivSteps - 1);
        state_d = StDiv;
      end
      StDiv: begin
        rem_d = trial_ge ? trial_diff[FreqW-1:0] : trial[FreqW-1:0];
        num_d = {num_q[NumW-2:0], trial_ge};
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_ticks_d = result;
          if (cmd_q == CmdCommit) begin
            base_d  = result;
            accum_d = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ----- rtl/core/stt_checker.sv -----
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the sample timestamp tracker, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [stt_pkg::CmdW-1:0]    in_command_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [stt_pkg::TsW-1:0]     out_ticks_i
);
  import stt_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_ticks_i))
    else $error("stalled result changed");

  // State-only commands finish in the transfer cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_command_i == CmdLoad || in_command_i == CmdAdd) |=> in_ready_i)
    else $error("not ready after load or add");

  // A converting command closes the channel after it transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_command_i == CmdCommit || in_command_i == CmdPeek || in_command_i == CmdFrame)
    |=> !in_ready_i)
    else $error("ready during conversion");

endmodule

bind sample_timestamp_tracker stt_checker u_stt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_ticks_i  (out_o.ticks)
);
